/* sv/lralu_pkg.sv */
// Shared types, command codes and flag positions of the handheld CPU ALU.
package lralu_pkg;

  localparam int CMD_W   = 5;
  localparam int WORD_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int FLAGS_W = 4;

  // Flag bit positions
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  // Decimal adjust constants
  localparam logic [9:0] DAA_LOW_FIX  = 10'h006;
  localparam logic [9:0] DAA_HIGH_FIX = 10'h060;
  localparam logic [9:0] DAA_HIGH_LIM = 10'h09F;
  localparam logic [3:0] DAA_DIGIT_MAX = 4'd9;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 5'd0,
    CMD_ADC    = 5'd1,
    CMD_SUB    = 5'd2,
    CMD_SBC    = 5'd3,
    CMD_AND    = 5'd4,
    CMD_OR     = 5'd5,
    CMD_XOR    = 5'd6,
    CMD_CP     = 5'd7,
    CMD_INC    = 5'd8,
    CMD_DEC    = 5'd9,
    CMD_ADD16  = 5'd10,
    CMD_SUB16  = 5'd11,
    CMD_INC16  = 5'd12,
    CMD_DEC16  = 5'd13,
    CMD_CPL    = 5'd14,
    CMD_CCF    = 5'd15,
    CMD_SCF    = 5'd16,
    CMD_DAA    = 5'd17,
    CMD_RLC    = 5'd18,
    CMD_RRC    = 5'd19,
    CMD_RL     = 5'd20,
    CMD_RR     = 5'd21,
    CMD_SLA    = 5'd22,
    CMD_SRA    = 5'd23,
    CMD_SRL    = 5'd24,
    CMD_SWAP   = 5'd25,
    CMD_BIT    = 5'd26,
    CMD_SET    = 5'd27,
    CMD_RES    = 5'd28,
    CMD_SP_OFS = 5'd29
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [WORD_W-1:0]  operand_a;
    logic [WORD_W-1:0]  operand_b;
    logic [FLAGS_W-1:0] flags_in;
    logic               accumulator_form;
  } alu_in_t;

  typedef struct packed {
    logic [WORD_W-1:0]  result;
    logic [FLAGS_W-1:0] flags_out;
  } alu_out_t;

endpackage

/* sv/lralu_exec.sv */
// Single-pass operation logic: result word and new flags for one command.
module lralu_exec (
  input  lralu_pkg::alu_in_t  op,
  output lralu_pkg::alu_out_t res
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic [15:0] wa;
  logic [15:0] wb;
  logic [3:0]  fi;
  logic        cin;
  logic        cuse;
  logic [8:0]  sum8;
  logic [4:0]  sum4;
  logic [8:0]  dif8;
  logic [4:0]  dif4;
  logic [16:0] sum16;
  logic [12:0] sum12;
  logic [16:0] dif16;
  logic [15:0] ofs;
  logic [7:0]  mask;
  logic [9:0]  daa_t1;
  logic [9:0]  daa_t2;
  logic        daa_c;
  logic [15:0] r;
  logic [3:0]  f;
  logic        zsel;

  assign a    = op.operand_a[7:0];
  assign b    = op.operand_b[7:0];
  assign wa   = op.operand_a;
  assign wb   = op.operand_b;
  assign fi   = op.flags_in;
  assign cin  = op.flags_in[lralu_pkg::FLAG_C];
  assign cuse = ((op.command == lralu_pkg::CMD_ADC) || (op.command == lralu_pkg::CMD_SBC))
                ? cin : 1'b0;

  assign sum8  = {1'b0, a} + {1'b0, b} + {8'd0, cuse};
  assign sum4  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cuse};
  assign dif8  = {1'b0, a} - {1'b0, b} - {8'd0, cuse};
  assign dif4  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cuse};
  assign sum16 = {1'b0, wa} + {1'b0, wb};
  assign sum12 = {1'b0, wa[11:0]} + {1'b0, wb[11:0]};
  assign dif16 = {1'b0, wa} - {1'b0, wb};
  assign ofs   = {{8{b[7]}}, b};
  assign mask  = 8'd1 << b[2:0];

  // Decimal adjust: add path may carry into bit 8, subtract path wraps in a byte
  always_comb begin
    daa_c = cin;
    if (!fi[lralu_pkg::FLAG_N]) begin
      daa_t1 = {2'b00, a};
      if (fi[lralu_pkg::FLAG_H] || (a[3:0] > lralu_pkg::DAA_DIGIT_MAX)) begin
        daa_t1 = daa_t1 + lralu_pkg::DAA_LOW_FIX;
      end
      daa_t2 = daa_t1;
      if (cin || (daa_t1 > lralu_pkg::DAA_HIGH_LIM)) begin
        daa_t2 = daa_t1 + lralu_pkg::DAA_HIGH_FIX;
        daa_c  = 1'b1;
      end
    end else begin
      daa_t1 = {2'b00, a};
      if (fi[lralu_pkg::FLAG_H]) begin
        daa_t1 = {2'b00, daa_t1[7:0] - lralu_pkg::DAA_LOW_FIX[7:0]};
      end
      daa_t2 = daa_t1;
      if (cin) begin
        daa_t2 = daa_t1 - lralu_pkg::DAA_HIGH_FIX;
      end
    end
  end

  always_comb begin
    r    = '0;
    f    = fi;
    zsel = 1'b0;
    unique case (op.command) inside
      lralu_pkg::CMD_ADD, lralu_pkg::CMD_ADC: begin
        r    = {8'd0, sum8[7:0]};
        f    = {1'b0, 1'b0, sum4[4], sum8[8]};
        zsel = 1'b1;
      end
      lralu_pkg::CMD_SUB, lralu_pkg::CMD_SBC, lralu_pkg::CMD_CP: begin
        r    = {8'd0, dif8[7:0]};
        f    = {1'b0, 1'b1, dif4[4], dif8[8]};
        zsel = 1'b1;
      end
      lralu_pkg::CMD_AND: begin
        r    = {8'd0, a & b};
        f    = 4'b0010;
        zsel = 1'b1;
      end
      lralu_pkg::CMD_OR: begin
        r    = {8'd0, a | b};
        f    = 4'b0000;
        zsel = 1'b1;
      end
      lralu_pkg::CMD_XOR: begin
        r    = {8'd0, a ^ b};
        f    = 4'b0000;
        zsel = 1'b1;
      end
      lralu_pkg::CMD_INC: begin
        r    = {8'd0, sum8[7:0]};
        f    = {1'b0, 1'b0, sum4[4], cin};
        zsel = 1'b1;
      end
      lralu_pkg::CMD_DEC: begin
        r    = {8'd0, dif8[7:0]};
        f    = {1'b0, 1'b1, dif4[4], cin};
        zsel = 1'b1;
      end
      lralu_pkg::CMD_ADD16: begin
        r = sum16[15:0];
        f = {fi[lralu_pkg::FLAG_Z], 1'b0, sum12[12], sum16[16]};
      end
      lralu_pkg::CMD_SUB16: begin
        r = dif16[15:0];
        f = {fi[3:1], dif16[16]};
      end
      lralu_pkg::CMD_INC16: r = sum16[15:0];
      lralu_pkg::CMD_DEC16: r = dif16[15:0];
      lralu_pkg::CMD_CPL: begin
        r = {8'd0, ~a};
        f = fi | 4'b0110;
      end
      lralu_pkg::CMD_CCF: f = {fi[lralu_pkg::FLAG_Z], 1'b0, 1'b0, ~cin};
      lralu_pkg::CMD_SCF: f = {fi[lralu_pkg::FLAG_Z], 1'b0, 1'b0, 1'b1};
      lralu_pkg::CMD_DAA: begin
        r    = {8'd0, daa_t2[7:0]};
        f    = {1'b0, fi[lralu_pkg::FLAG_N], 1'b0, daa_c};
        zsel = 1'b1;
      end
      lralu_pkg::CMD_RLC: begin
        r    = {8'd0, a[6:0], a[7]};
        f    = {1'b0, 1'b0, 1'b0, a[7]};
        zsel = !op.accumulator_form;
      end
      lralu_pkg::CMD_RRC: begin
        r    = {8'd0, a[0], a[7:1]};
        f    = {1'b0, 1'b0, 1'b0, a[0]};
        zsel = !op.accumulator_form;
      end
      lralu_pkg::CMD_RL: begin
        r    = {8'd0, a[6:0], cin};
        f    = {1'b0, 1'b0, 1'b0, a[7]};
        zsel = !op.accumulator_form;
      end
      lralu_pkg::CMD_RR: begin
        r    = {8'd0, cin, a[7:1]};
        f    = {1'b0, 1'b0, 1'b0, a[0]};
        zsel = !op.accumulator_form;
      end
      lralu_pkg::CMD_SLA: begin
        r    = {8'd0, a[6:0], 1'b0};
        f    = {1'b0, 1'b0, 1'b0, a[7]};
        zsel = 1'b1;
      end
      lralu_pkg::CMD_SRA: begin
        r    = {8'd0, a[7], a[7:1]};
        f    = {1'b0, 1'b0, 1'b0, a[0]};
        zsel = 1'b1;
      end
      lralu_pkg::CMD_SRL: begin
        r    = {8'd0, 1'b0, a[7:1]};
        f    = {1'b0, 1'b0, 1'b0, a[0]};
        zsel = 1'b1;
      end
      lralu_pkg::CMD_SWAP: begin
        r    = {8'd0, a[3:0], a[7:4]};
        f    = 4'b0000;
        zsel = 1'b1;
      end
      lralu_pkg::CMD_BIT: begin
        r    = {8'd0, a & mask};
        f    = {1'b0, 1'b0, 1'b1, cin};
        zsel = 1'b1;
      end
      lralu_pkg::CMD_SET: r = {8'd0, a | mask};
      lralu_pkg::CMD_RES: r = {8'd0, a & ~mask};
      lralu_pkg::CMD_SP_OFS: begin
        // carries come from the unsigned low-byte add, not the signed sum
        r = wa + ofs;
        f = {1'b0, 1'b0, sum4[4], sum8[8]};
      end
      default: begin
        r = '0;
        f = fi;
      end
    endcase
    if (zsel) begin
      f[lralu_pkg::FLAG_Z] = (r[7:0] == 8'd0);
    end
  end

  assign res.result    = r;
  assign res.flags_out = f;

endmodule

/* sv/eight_bit_cpu_alu_with_flags_core.sv */
// Top level of the handheld CPU ALU: input register, operation logic, result register.
//
// Input channel: in_valid with command, operand_a, operand_b, flags_in and
// accumulator_form; the item transfers at a clock edge with in_valid high and
// in_stall low. Output channel: out_valid with result and flags_out; a result
// transfers at an edge with out_valid high and out_stall low.
// Every command yields exactly one result, in order of arrival.
// Each item goes from the input register through the operation logic into the
// result register, and transfers out from there.
// Throughput: one item per cycle while the receiver keeps out_stall low; the
// rate is set by the single-pass operation logic between the two registers.
// Reset (rst, synchronous, active high) empties both registers; no result is
// presented until new items arrive.
// When the receiver stalls, the result register holds its value, the input
// register holds the next item, and in_stall rises once both are occupied.
// Up to two items can sit in the block during a stall.
module eight_bit_cpu_alu_with_flags_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [lralu_pkg::CMD_W-1:0]     command,
  input  logic [lralu_pkg::WORD_W-1:0]    operand_a,
  input  logic [lralu_pkg::WORD_W-1:0]    operand_b,
  input  logic [lralu_pkg::FLAGS_W-1:0]   flags_in,
  input  logic                            accumulator_form,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lralu_pkg::WORD_W-1:0]    result,
  output logic [lralu_pkg::FLAGS_W-1:0]   flags_out
);

  lralu_pkg::alu_in_t  stage_in;
  logic                stage_valid;
  lralu_pkg::alu_out_t exec_res;
  lralu_pkg::alu_out_t out_reg;
  logic                out_reg_valid;
  logic                advance;
  logic                in_xfer;

  // Move the held item forward whenever the result register is free or draining
  assign advance  = !out_reg_valid || !out_stall;
  assign in_stall = stage_valid && !advance;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!stage_valid || advance) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stage_in.command          <= command;
      stage_in.operand_a        <= operand_a;
      stage_in.operand_b        <= operand_b;
      stage_in.flags_in         <= flags_in;
      stage_in.accumulator_form <= accumulator_form;
    end
  end

  lralu_exec u_exec (
    .op  (stage_in),
    .res (exec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_reg_valid <= 1'b0;
    end else if (advance) begin
      out_reg_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      out_reg <= exec_res;
    end
  end

  assign out_valid = out_reg_valid;
  assign result    = out_reg.result;
  assign flags_out = out_reg.flags_out;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (stage_valid && out_reg_valid))
    else $error("input stalled without both registers occupied");

  a_xfer_fills_stage: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> stage_valid)
    else $error("input transfer did not fill the input register");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !advance) |=> (stage_valid && $stable(stage_in)))
    else $error("held item changed while blocked");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && advance) |=> (out_reg_valid && (out_reg == $past(exec_res))))
    else $error("result register did not capture the advancing item");

endmodule

/* dv/eight_bit_cpu_alu_with_flags_core_tb.sv */
// Self-checking testbench for the handheld CPU ALU: directed and random operations.
`timescale 1ns / 1ps

module eight_bit_cpu_alu_with_flags_core_tb;

  localparam logic [lralu_pkg::CMD_W-1:0] CMD_SPARE_LO = 5'd30;
  localparam logic [lralu_pkg::CMD_W-1:0] CMD_SPARE_HI = 5'd31;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_AT_OP = 150;
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned RANDOM_OPS = 500;
  localparam logic [7:0] CORNER_BYTES [10] = '{8'h00, 8'h01, 8'h0F, 8'h10, 8'h7F,
                                               8'h80, 8'hFE, 8'hFF, 8'h99, 8'h9A};

  class alu_scoreboard;
    lralu_pkg::alu_out_t pending_results[$];
    int unsigned mismatch_count;

    function lralu_pkg::alu_out_t predict_alu(lralu_pkg::alu_in_t op);
      logic [7:0] a, b, r8, mask;
      logic [15:0] wa, wb, r16;
      logic [3:0] fi, f;
      logic cin, c, cout, wide;
      logic [8:0] s9;
      logic [16:0] s17;
      logic [9:0] d10;
      lralu_pkg::alu_out_t res;
      a = op.operand_a[7:0];
      b = op.operand_b[7:0];
      wa = op.operand_a;
      wb = op.operand_b;
      fi = op.flags_in;
      cin = fi[lralu_pkg::FLAG_C];
      mask = 8'h01 << b[2:0];
      r8 = 8'h00;
      r16 = 16'h0000;
      wide = 1'b0;
      f = fi;
      case (op.command)
        lralu_pkg::CMD_ADD, lralu_pkg::CMD_ADC: begin
          c = (op.command == lralu_pkg::CMD_ADC) ? cin : 1'b0;
          s9 = {1'b0, a} + {1'b0, b} + c;
          r8 = s9[7:0];
          f = '0;
          f[lralu_pkg::FLAG_Z] = (r8 == 8'h00);
          f[lralu_pkg::FLAG_H] = ({1'b0, a[3:0]} + {1'b0, b[3:0]} + c) > 5'h0F;
          f[lralu_pkg::FLAG_C] = s9[8];
        end
        lralu_pkg::CMD_SUB, lralu_pkg::CMD_SBC, lralu_pkg::CMD_CP: begin
          c = (op.command == lralu_pkg::CMD_SBC) ? cin : 1'b0;
          r8 = a - b - c;
          f = '0;
          f[lralu_pkg::FLAG_Z] = (r8 == 8'h00);
          f[lralu_pkg::FLAG_N] = 1'b1;
          f[lralu_pkg::FLAG_H] = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + c);
          f[lralu_pkg::FLAG_C] = {1'b0, a} < ({1'b0, b} + c);
        end
        lralu_pkg::CMD_AND: begin
          r8 = a & b;
          f = '0;
          f[lralu_pkg::FLAG_Z] = (r8 == 8'h00);
          f[lralu_pkg::FLAG_H] = 1'b1;
        end
        lralu_pkg::CMD_OR, lralu_pkg::CMD_XOR: begin
          r8 = (op.command == lralu_pkg::CMD_OR) ? (a | b) : (a ^ b);
          f = '0;
          f[lralu_pkg::FLAG_Z] = (r8 == 8'h00);
        end
        lralu_pkg::CMD_INC: begin
          r8 = a + b;
          f = '0;
          f[lralu_pkg::FLAG_Z] = (r8 == 8'h00);
          f[lralu_pkg::FLAG_H] = ({1'b0, a[3:0]} + {1'b0, b[3:0]}) > 5'h0F;
          f[lralu_pkg::FLAG_C] = cin;
        end
        lralu_pkg::CMD_DEC: begin
          r8 = a - b;
          f = '0;
          f[lralu_pkg::FLAG_Z] = (r8 == 8'h00);
          f[lralu_pkg::FLAG_N] = 1'b1;
          f[lralu_pkg::FLAG_H] = a[3:0] < b[3:0];
          f[lralu_pkg::FLAG_C] = cin;
        end
        lralu_pkg::CMD_ADD16: begin
          wide = 1'b1;
          s17 = {1'b0, wa} + {1'b0, wb};
          r16 = s17[15:0];
          f = '0;
          f[lralu_pkg::FLAG_Z] = fi[lralu_pkg::FLAG_Z];
          f[lralu_pkg::FLAG_H] = ({1'b0, wa[11:0]} + {1'b0, wb[11:0]}) > 13'h0FFF;
          f[lralu_pkg::FLAG_C] = s17[16];
        end
        lralu_pkg::CMD_SUB16: begin
          wide = 1'b1;
          r16 = wa - wb;
          f[lralu_pkg::FLAG_C] = wa < wb;
        end
        lralu_pkg::CMD_INC16: begin
          wide = 1'b1;
          r16 = wa + wb;
        end
        lralu_pkg::CMD_DEC16: begin
          wide = 1'b1;
          r16 = wa - wb;
        end
        lralu_pkg::CMD_CPL: begin
          r8 = ~a;
          f[lralu_pkg::FLAG_N] = 1'b1;
          f[lralu_pkg::FLAG_H] = 1'b1;
        end
        lralu_pkg::CMD_CCF, lralu_pkg::CMD_SCF: begin
          f = '0;
          f[lralu_pkg::FLAG_Z] = fi[lralu_pkg::FLAG_Z];
          f[lralu_pkg::FLAG_C] = (op.command == lralu_pkg::CMD_SCF) ? 1'b1 : ~cin;
        end
        lralu_pkg::CMD_DAA: begin
          d10 = {2'b00, a};
          c = cin;
          if (!fi[lralu_pkg::FLAG_N]) begin
            if (fi[lralu_pkg::FLAG_H] || a[3:0] > lralu_pkg::DAA_DIGIT_MAX)
              d10 = d10 + lralu_pkg::DAA_LOW_FIX;
            if (c || d10 > lralu_pkg::DAA_HIGH_LIM) begin
              d10 = d10 + lralu_pkg::DAA_HIGH_FIX;
              c = 1'b1;
            end
          end else begin
            if (fi[lralu_pkg::FLAG_H]) d10 = (d10 - lralu_pkg::DAA_LOW_FIX) & 10'h0FF;
            if (c) d10 = d10 - lralu_pkg::DAA_HIGH_FIX;
          end
          r8 = d10[7:0];
          f = '0;
          f[lralu_pkg::FLAG_Z] = (r8 == 8'h00);
          f[lralu_pkg::FLAG_N] = fi[lralu_pkg::FLAG_N];
          f[lralu_pkg::FLAG_C] = c;
        end
        lralu_pkg::CMD_RLC, lralu_pkg::CMD_RRC, lralu_pkg::CMD_RL, lralu_pkg::CMD_RR: begin
          case (op.command)
            lralu_pkg::CMD_RLC: r8 = {a[6:0], a[7]};
            lralu_pkg::CMD_RRC: r8 = {a[0], a[7:1]};
            lralu_pkg::CMD_RL:  r8 = {a[6:0], cin};
            default: r8 = {cin, a[7:1]};
          endcase
          cout = (op.command == lralu_pkg::CMD_RLC || op.command == lralu_pkg::CMD_RL)
                 ? a[7] : a[0];
          f = '0;
          // accumulator forms always leave Z clear
          f[lralu_pkg::FLAG_Z] = !op.accumulator_form && (r8 == 8'h00);
          f[lralu_pkg::FLAG_C] = cout;
        end
        lralu_pkg::CMD_SLA, lralu_pkg::CMD_SRA, lralu_pkg::CMD_SRL,
        lralu_pkg::CMD_SWAP: begin
          case (op.command)
            lralu_pkg::CMD_SLA: r8 = {a[6:0], 1'b0};
            lralu_pkg::CMD_SRA: r8 = {a[7], a[7:1]};
            lralu_pkg::CMD_SRL: r8 = {1'b0, a[7:1]};
            default: r8 = {a[3:0], a[7:4]};
          endcase
          f = '0;
          f[lralu_pkg::FLAG_Z] = (r8 == 8'h00);
          if (op.command == lralu_pkg::CMD_SLA) f[lralu_pkg::FLAG_C] = a[7];
          else if (op.command != lralu_pkg::CMD_SWAP) f[lralu_pkg::FLAG_C] = a[0];
        end
        lralu_pkg::CMD_BIT: begin
          r8 = a & mask;
          f = '0;
          f[lralu_pkg::FLAG_Z] = (r8 == 8'h00);
          f[lralu_pkg::FLAG_H] = 1'b1;
          f[lralu_pkg::FLAG_C] = cin;
        end
        lralu_pkg::CMD_SET: r8 = a | mask;
        lralu_pkg::CMD_RES: r8 = a & ~mask;
        lralu_pkg::CMD_SP_OFS: begin
          wide = 1'b1;
          r16 = wa + {{8{b[7]}}, b};
          f = '0;
          f[lralu_pkg::FLAG_H] = ({1'b0, wa[3:0]} + {1'b0, b[3:0]}) > 5'h0F;
          f[lralu_pkg::FLAG_C] = ({1'b0, wa[7:0]} + {1'b0, b}) > 9'h0FF;
        end
        default: f = fi;
      endcase
      res.result = wide ? r16 : {8'h00, r8};
      res.flags_out = f;
      return res;
    endfunction

    function void note_operation(lralu_pkg::alu_in_t op);
      pending_results.push_back(predict_alu(op));
    endfunction

    function void check_result(logic [lralu_pkg::WORD_W-1:0] res,
                               logic [lralu_pkg::FLAGS_W-1:0] flags);
      lralu_pkg::alu_out_t exp_res;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result %h flags %b with nothing outstanding", res, flags);
        return;
      end
      exp_res = pending_results.pop_front();
      if (res !== exp_res.result || flags !== exp_res.flags_out) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("mismatch: result %h flags %b, expected result %h flags %b",
                   res, flags, exp_res.result, exp_res.flags_out);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [lralu_pkg::CMD_W-1:0] command;
  logic [lralu_pkg::WORD_W-1:0] operand_a;
  logic [lralu_pkg::WORD_W-1:0] operand_b;
  logic [lralu_pkg::FLAGS_W-1:0] flags_in;
  logic accumulator_form;
  logic out_valid;
  logic out_stall;
  logic [lralu_pkg::WORD_W-1:0] result;
  logic [lralu_pkg::FLAGS_W-1:0] flags_out;

  alu_scoreboard sb = new();
  bit quiet = 1'b0;
  int unsigned ops_accepted = 0;
  int unsigned cycle_count = 0;

  eight_bit_cpu_alu_with_flags_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .operand_a(operand_a),
    .operand_b(operand_b),
    .flags_in(flags_in),
    .accumulator_form(accumulator_form),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result(result),
    .flags_out(flags_out)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic lralu_pkg::alu_in_t make_op(logic [lralu_pkg::CMD_W-1:0] cmd,
                                                 logic [lralu_pkg::WORD_W-1:0] a,
                                                 logic [lralu_pkg::WORD_W-1:0] b,
                                                 logic [lralu_pkg::FLAGS_W-1:0] f,
                                                 logic acc);
    lralu_pkg::alu_in_t op;
    op.command = cmd;
    op.operand_a = a;
    op.operand_b = b;
    op.flags_in = f;
    op.accumulator_form = acc;
    return op;
  endfunction

  function automatic logic [lralu_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(5, 0))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return {8'($urandom), CORNER_BYTES[$urandom_range(9, 0)]};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic lralu_pkg::alu_in_t random_op();
    return make_op(5'($urandom_range(29, 0)), pick_word(), pick_word(),
                   4'($urandom_range(15, 0)), 1'($urandom_range(1, 0)));
  endfunction

  task automatic send_op(lralu_pkg::alu_in_t op);
    while (!quiet && $urandom_range(99, 0) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= op.command;
    operand_a <= op.operand_a;
    operand_b <= op.operand_b;
    flags_in <= op.flags_in;
    accumulator_form <= op.accumulator_form;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (sb.pending_results.size() != 0);
  endtask

  // note each accepted transfer on the input side
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      sb.note_operation(make_op(command, operand_a, operand_b, flags_in, accumulator_form));
      ops_accepted++;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(result, flags_out);
  end

  // receiver: random stalls plus one long hold-off to back up the block
  initial begin
    int unsigned hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && ops_accepted >= HOLD_AT_OP) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !quiet && ($urandom_range(99, 0) < 8);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("eight_bit_cpu_alu_with_flags_core_tb failed");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    command <= '0;
    operand_a <= '0;
    operand_b <= '0;
    flags_in <= '0;
    accumulator_form <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_op(make_op(lralu_pkg::CMD_ADD,    16'hA5FF, 16'h5A01, 4'b0000, 1'b0));
    send_op(make_op(lralu_pkg::CMD_ADC,    16'h000F, 16'h0000, 4'b0001, 1'b0));
    send_op(make_op(lralu_pkg::CMD_SUB,    16'hFF00, 16'h0001, 4'b1111, 1'b1));
    send_op(make_op(lralu_pkg::CMD_SBC,    16'h0010, 16'h000F, 4'b0001, 1'b0));
    send_op(make_op(lralu_pkg::CMD_AND,    16'h00F0, 16'h000F, 4'b0000, 1'b0));
    send_op(make_op(lralu_pkg::CMD_OR,     16'hFF00, 16'hFF00, 4'b1111, 1'b0));
    send_op(make_op(lralu_pkg::CMD_XOR,    16'h00FF, 16'h00FF, 4'b0000, 1'b0));
    send_op(make_op(lralu_pkg::CMD_CP,     16'h003C, 16'h003C, 4'b0000, 1'b0));
    send_op(make_op(lralu_pkg::CMD_INC,    16'h000F, 16'h0001, 4'b0001, 1'b0));
    send_op(make_op(lralu_pkg::CMD_DEC,    16'h0010, 16'h0001, 4'b0001, 1'b0));
    send_op(make_op(lralu_pkg::CMD_ADD16,  16'h0FFF, 16'h0001, 4'b1000, 1'b0));
    send_op(make_op(lralu_pkg::CMD_ADD16,  16'hFFFF, 16'h0001, 4'b0111, 1'b0));
    send_op(make_op(lralu_pkg::CMD_SUB16,  16'h0000, 16'h0001, 4'b1110, 1'b0));
    send_op(make_op(lralu_pkg::CMD_INC16,  16'hFFFF, 16'h0001, 4'b1111, 1'b0));
    send_op(make_op(lralu_pkg::CMD_DEC16,  16'h0000, 16'h0001, 4'b0101, 1'b0));
    send_op(make_op(lralu_pkg::CMD_CPL,    16'h1255, 16'h0000, 4'b1001, 1'b0));
    send_op(make_op(lralu_pkg::CMD_CCF,    16'h0000, 16'h0000, 4'b1111, 1'b0));
    send_op(make_op(lralu_pkg::CMD_SCF,    16'h0000, 16'h0000, 4'b0110, 1'b0));
    send_op(make_op(lralu_pkg::CMD_DAA,    16'h009A, 16'h0000, 4'b0000, 1'b0));
    send_op(make_op(lralu_pkg::CMD_DAA,    16'h0000, 16'h0000, 4'b0111, 1'b0));
    send_op(make_op(lralu_pkg::CMD_RLC,    16'h0080, 16'h0000, 4'b0000, 1'b1));
    send_op(make_op(lralu_pkg::CMD_RRC,    16'h0000, 16'h0000, 4'b0000, 1'b1));
    send_op(make_op(lralu_pkg::CMD_RL,     16'h0080, 16'h0000, 4'b0000, 1'b0));
    send_op(make_op(lralu_pkg::CMD_RR,     16'h0001, 16'h0000, 4'b0001, 1'b0));
    send_op(make_op(lralu_pkg::CMD_SLA,    16'h0080, 16'h0000, 4'b0000, 1'b0));
    send_op(make_op(lralu_pkg::CMD_SRA,    16'h0081, 16'h0000, 4'b0000, 1'b0));
    send_op(make_op(lralu_pkg::CMD_SRL,    16'h0001, 16'h0000, 4'b0000, 1'b0));
    send_op(make_op(lralu_pkg::CMD_SWAP,   16'h00F0, 16'h0000, 4'b0000, 1'b0));
    send_op(make_op(lralu_pkg::CMD_BIT,    16'h007F, 16'hFF0F, 4'b0101, 1'b0));
    send_op(make_op(lralu_pkg::CMD_SET,    16'h0000, 16'h0003, 4'b1010, 1'b0));
    send_op(make_op(lralu_pkg::CMD_RES,    16'h00FF, 16'h0000, 4'b0101, 1'b0));
    send_op(make_op(lralu_pkg::CMD_SP_OFS, 16'hFFF8, 16'h0008, 4'b1111, 1'b0));
    send_op(make_op(lralu_pkg::CMD_SP_OFS, 16'h0005, 16'hFF80, 4'b1100, 1'b0));
    send_op(make_op(CMD_SPARE_LO, 16'hFFFF, 16'hFFFF, 4'b1010, 1'b1));
    send_op(make_op(CMD_SPARE_HI, 16'h1234, 16'h5678, 4'b0101, 1'b0));
    in_valid <= 1'b0;
    // hold the sender until the block has drained
    wait_drained();

    for (int i = 0; i < RANDOM_OPS; i++) begin
      quiet = (i >= 300 && i < 420);
      send_op(random_op());
    end
    quiet = 1'b0;
    in_valid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk);

    if (sb.mismatch_count == 0 && sb.pending_results.size() == 0)
      $display("eight_bit_cpu_alu_with_flags_core_tb passed");
    else
      $display("eight_bit_cpu_alu_with_flags_core_tb failed");
    $finish;
  end

endmodule

/* eight_bit_cpu_alu_with_flags_core.f */
sv/lralu_pkg.sv
sv/lralu_exec.sv
sv/eight_bit_cpu_alu_with_flags_core.sv
dv/eight_bit_cpu_alu_with_flags_core_tb.sv
